// File: src/rss_pkg.sv
// shared types and constants for the robot safety supervisor
`default_nettype none

package rss_pkg;

  // input kinds carried in tuser
  localparam logic [1:0] MODE_TICK  = 2'd0;
  localparam logic [1:0] MODE_ECHO  = 2'd1;
  localparam logic [1:0] MODE_FRAME = 2'd2;

  // override codes
  localparam logic [2:0] OVR_CLEAR  = 3'd0;
  localparam logic [2:0] OVR_MANUAL = 3'd1;
  localparam logic [2:0] OVR_COMMS  = 3'd2;
  localparam logic [2:0] OVR_OBST   = 3'd3;
  localparam logic [2:0] OVR_ESTOP  = 3'd4;

  // configuration register indexes
  localparam logic [2:0] CFG_STOP_CM     = 3'd0;
  localparam logic [2:0] CFG_CLEAR_CM    = 3'd1;
  localparam logic [2:0] CFG_MIN_VALID   = 3'd2;
  localparam logic [2:0] CFG_MAX_VALID   = 3'd3;
  localparam logic [2:0] CFG_AGREE_READS = 3'd4;
  localparam logic [2:0] CFG_FAULT_RUN   = 3'd5;
  localparam logic [2:0] CFG_COMMS_LIMIT = 3'd6;
  localparam logic [2:0] CFG_DEBOUNCE    = 3'd7;

  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 16;

  localparam logic [15:0] CNT_MAX   = 16'hFFFF;
  localparam logic [7:0]  AGREE_MAX = 8'hFF;
  localparam logic [13:0] DIST_MAX  = 14'h3FFF;
  localparam logic [14:0] DIST_NONE = 15'h7FFF;

  // 58 us per cm times 16 sub-steps
  localparam int unsigned DivQ4   = 928;
  localparam int unsigned RecipSh = 30;

  typedef struct packed {
    logic        teleop_active;
    logic        estop_level;
    logic [15:0] echo_width_us;
    logic [1:0]  mode;
  } in_t;

  typedef struct packed {
    logic        valid;
    logic [13:0] q4;
  } echo_t;

  typedef struct packed {
    logic        ping_request;
    logic        fault_notice;
    logic        sensor_faulty;
    logic [14:0] distance_q4;
    logic        comms_silent;
    logic        estop_active;
    logic        obstacle_blocked;
    logic        motion_forbidden;
    logic [2:0]  override_code;
  } res_t;

endpackage

`default_nettype wire

// File: src/rss_echo.sv
// echo width to distance conversion and validity window
`default_nettype none

module rss_echo #(
  parameter int unsigned ECHO_TIMEOUT_US = 30000,
  parameter int unsigned SCALE_Q8        = 256
) (
  input  logic [15:0]  width_i,
  input  logic [9:0]   min_cm_i,
  input  logic [9:0]   max_cm_i,
  output rss_pkg::echo_t echo_o
);
  import rss_pkg::*;

  // ceil(SCALE_Q8 * 2^30 / 928), exact floor for any 16-bit width
  localparam logic [31:0] Recip =
    32'(((64'(SCALE_Q8) << RecipSh) + 64'(DivQ4 - 1)) / 64'(DivQ4));
  localparam logic [15:0] Timeout = 16'(ECHO_TIMEOUT_US);

  logic [47:0] prod;
  logic [17:0] quot;
  logic [13:0] q4;
  logic        in_time;

  always_comb begin
    prod    = 48'(width_i) * 48'(Recip);
    quot    = prod[47:RecipSh];
    q4      = (quot > 18'(DIST_MAX)) ? DIST_MAX : quot[13:0];
    in_time = (width_i != 16'd0) && (width_i <= Timeout);
    echo_o.q4    = q4;
    echo_o.valid = in_time && (q4 >= {min_cm_i, 4'b0000}) && (q4 <= {max_cm_i, 4'b0000});
  end

endmodule

`default_nettype wire

// File: src/robot_safety_supervisor.sv
// robot safety supervisor top level: obstacle, e-stop, ping and comms watchdog
//
//  channel  | dir | tdata (low bit up)                                  | tuser
//  s_axis   | in  | echo_width_us[15:0] estop_level[16] teleop[17]     | mode[1:0]
//  m_axis   | out | override_code motion_forbidden obstacle_blocked    | -
//           |     | estop_active comms_silent distance_q4 sensor_faulty |
//           |     | fault_notice ping_request                           |
//  cfg      | in  | cfg_we_i, cfg_idx_i, cfg_wdata_i                    | -
//
// an item passes through the input register and then the result register
// one item per cycle unless m_axis stalls, set by the single state update stage
// reset clears the valid and state registers and loads config defaults, no clearing pass
// a stalled result holds the result register, the input register then fills and
// tready drops until the result is taken
`default_nettype none

module robot_safety_supervisor #(
  parameter int unsigned PING_PERIOD_MS  = 60,
  parameter int unsigned ECHO_TIMEOUT_US = 30000,
  parameter int unsigned SCALE_Q8        = 256
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,  // echo_width_us, estop_level, teleop_active
  input  logic [1:0]  s_axis_tuser,  // mode
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,  // override_code, motion_forbidden, obstacle_blocked,
                                     // estop_active, comms_silent, distance_q4,
                                     // sensor_faulty, fault_notice, ping_request
  input  logic        cfg_we_i,
  input  logic [rss_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [rss_pkg::CfgDataW-1:0] cfg_wdata_i
);
  import rss_pkg::*;

  localparam logic [15:0] PingPeriod = 16'(PING_PERIOD_MS);

  // configuration
  logic [9:0]  stop_cm_q, clear_cm_q, min_cm_q, max_cm_q;
  logic [7:0]  agree_reads_q;
  logic [15:0] fault_run_q, comms_limit_q, debounce_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stop_cm_q     <= 10'd20;
      clear_cm_q    <= 10'd35;
      min_cm_q      <= 10'd2;
      max_cm_q      <= 10'd400;
      agree_reads_q <= 8'd3;
      fault_run_q   <= 16'd20;
      comms_limit_q <= 16'd2000;
      debounce_q    <= 16'd20;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_STOP_CM:     stop_cm_q     <= cfg_wdata_i[9:0];
        CFG_CLEAR_CM:    clear_cm_q    <= cfg_wdata_i[9:0];
        CFG_MIN_VALID:   min_cm_q      <= cfg_wdata_i[9:0];
        CFG_MAX_VALID:   max_cm_q      <= cfg_wdata_i[9:0];
        CFG_AGREE_READS: agree_reads_q <= cfg_wdata_i[7:0];
        CFG_FAULT_RUN:   fault_run_q   <= cfg_wdata_i;
        CFG_COMMS_LIMIT: comms_limit_q <= cfg_wdata_i;
        CFG_DEBOUNCE:    debounce_q    <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // input and result registers
  logic  in_vld_q, out_vld_q, advance;
  in_t   in_q;
  res_t  res_d, res_q;

  assign advance       = in_vld_q && (!out_vld_q || m_axis_tready);
  assign s_axis_tready = !in_vld_q || advance;
  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {7'd0, res_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      if (s_axis_tready) in_vld_q <= s_axis_tvalid;
      if (advance) out_vld_q <= 1'b1;
      else if (m_axis_tready) out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_q.mode          <= s_axis_tuser;
      in_q.echo_width_us <= s_axis_tdata[15:0];
      in_q.estop_level   <= s_axis_tdata[16];
      in_q.teleop_active <= s_axis_tdata[17];
    end
    if (advance) res_q <= res_d;
  end

  // echo conversion
  echo_t echo;

  rss_echo #(
    .ECHO_TIMEOUT_US (ECHO_TIMEOUT_US),
    .SCALE_Q8        (SCALE_Q8)
  ) u_echo (
    .width_i  (in_q.echo_width_us),
    .min_cm_i (min_cm_q),
    .max_cm_i (max_cm_q),
    .echo_o   (echo)
  );

  // supervisor state
  logic        blocked_q, blocked_d, pend_q, pend_d, told_q, told_d;
  logic        ping_pend_q, ping_pend_d, estop_q, estop_d, lvl_q, lvl_d;
  logic        heard_q, heard_d;
  logic [7:0]  agree_q, agree_d;
  logic [15:0] inv_run_q, inv_run_d, ping_cnt_q, ping_cnt_d;
  logic [15:0] lvl_cnt_q, lvl_cnt_d, frame_cnt_q, frame_cnt_d;
  logic [14:0] dist_q, dist_d;

  logic        tick, want, faulty, notice, silent, ping_req;
  logic [13:0] thresh;
  logic [2:0]  code;

  always_comb begin
    blocked_d   = blocked_q;
    pend_d      = pend_q;
    told_d      = told_q;
    ping_pend_d = ping_pend_q;
    estop_d     = estop_q;
    lvl_d       = lvl_q;
    heard_d     = heard_q;
    agree_d     = agree_q;
    inv_run_d   = inv_run_q;
    ping_cnt_d  = ping_cnt_q;
    lvl_cnt_d   = lvl_cnt_q;
    frame_cnt_d = frame_cnt_q;
    dist_d      = dist_q;
    ping_req    = 1'b0;
    notice      = 1'b0;
    tick        = (in_q.mode == MODE_TICK);
    thresh      = blocked_q ? {clear_cm_q, 4'b0000} : {stop_cm_q, 4'b0000};
    want        = echo.valid && (echo.q4 <= thresh);

    if (tick) begin
      if (ping_cnt_q != CNT_MAX)  ping_cnt_d  = ping_cnt_q + 16'd1;
      if (lvl_cnt_q != CNT_MAX)   lvl_cnt_d   = lvl_cnt_q + 16'd1;
      if (frame_cnt_q != CNT_MAX) frame_cnt_d = frame_cnt_q + 16'd1;
    end

    // e-stop debounce
    if (in_q.estop_level != lvl_q) begin
      lvl_d     = in_q.estop_level;
      lvl_cnt_d = 16'd0;
    end
    if (lvl_cnt_d >= debounce_q) estop_d = lvl_d;

    case (in_q.mode)
      MODE_ECHO: begin
        ping_pend_d = 1'b0;
        if (echo.valid) begin
          dist_d    = {1'b0, echo.q4};
          inv_run_d = 16'd0;
          told_d    = 1'b0;
        end else begin
          dist_d = DIST_NONE;
          if (inv_run_q != CNT_MAX) inv_run_d = inv_run_q + 16'd1;
        end
        if (want == pend_q) begin
          if (agree_q != AGREE_MAX) agree_d = agree_q + 8'd1;
        end else begin
          pend_d  = want;
          agree_d = 8'd1;
        end
        if (agree_d >= agree_reads_q) blocked_d = pend_d;
      end
      MODE_FRAME: begin
        frame_cnt_d = 16'd0;
        heard_d     = 1'b1;
      end
      default: ;
    endcase

    // ping cadence
    if (tick && (ping_cnt_d >= PingPeriod)) begin
      ping_cnt_d  = 16'd0;
      if (ping_pend_d) dist_d = DIST_NONE;
      ping_pend_d = 1'b1;
      ping_req    = 1'b1;
    end

    faulty = (inv_run_d >= fault_run_q);
    if (faulty && !told_d) begin
      told_d = 1'b1;
      notice = 1'b1;
    end

    silent = !heard_d || (frame_cnt_d > comms_limit_q);
    if (estop_d)                 code = OVR_ESTOP;
    else if (blocked_d)          code = OVR_OBST;
    else if (silent)             code = OVR_COMMS;
    else if (in_q.teleop_active) code = OVR_MANUAL;
    else                         code = OVR_CLEAR;

    res_d.override_code    = code;
    res_d.motion_forbidden = code inside {OVR_ESTOP, OVR_OBST, OVR_COMMS};
    res_d.obstacle_blocked = blocked_d;
    res_d.estop_active     = estop_d;
    res_d.comms_silent     = silent;
    res_d.distance_q4      = dist_d;
    res_d.sensor_faulty    = faulty;
    res_d.fault_notice     = notice;
    res_d.ping_request     = ping_req;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      blocked_q   <= 1'b0;
      pend_q      <= 1'b0;
      told_q      <= 1'b0;
      ping_pend_q <= 1'b0;
      estop_q     <= 1'b0;
      lvl_q       <= 1'b0;
      heard_q     <= 1'b0;
      agree_q     <= 8'd0;
      inv_run_q   <= 16'd0;
      ping_cnt_q  <= 16'd0;
      lvl_cnt_q   <= 16'd0;
      frame_cnt_q <= 16'd0;
      dist_q      <= DIST_NONE;
    end else if (advance) begin
      blocked_q   <= blocked_d;
      pend_q      <= pend_d;
      told_q      <= told_d;
      ping_pend_q <= ping_pend_d;
      estop_q     <= estop_d;
      lvl_q       <= lvl_d;
      heard_q     <= heard_d;
      agree_q     <= agree_d;
      inv_run_q   <= inv_run_d;
      ping_cnt_q  <= ping_cnt_d;
      lvl_cnt_q   <= lvl_cnt_d;
      frame_cnt_q <= frame_cnt_d;
      dist_q      <= dist_d;
    end
  end

`ifndef SYNTHESIS
  a_estop_wins: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && res_q.estop_active) |-> (res_q.override_code == OVR_ESTOP))
    else $error("estop_active without estopped override");

  a_notice_faulty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && res_q.fault_notice) |-> res_q.sensor_faulty)
    else $error("fault notice while sensor not faulty");

  a_told_notice: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(told_q) |-> (out_vld_q && res_q.fault_notice))
    else $error("fault episode started without a notice");

  a_ping_tick: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance && res_d.ping_request) |=> (ping_pend_q && (ping_cnt_q == 16'd0)))
    else $error("ping request without cadence restart");
`endif

endmodule

`default_nettype wire
